// ===== rtl/sarb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the stereo audio ring buffer
// no dependencies

package sarb_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 4;
  localparam int DROP_W     = 2;

  // beat widths on the stream ports
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the input beat into the item registers
    logic step1;    // first push, or pop read
    logic step2;    // second push
    logic load;     // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } status_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

// ===== rtl/sarb_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the stereo audio ring buffer: walks one item through its steps
// depends on sarb_pkg

module sarb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sarb_pkg::status_t status,
  output sarb_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP1 = 2'd1;
  localparam logic [1:0] ST_STEP2 = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  // a new beat can come in while the previous result is being loaded
  assign in_ready = (state == ST_IDLE) || ((state == ST_DONE) && status.out_free);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = take;
    unique case (state)
      ST_IDLE: begin
        if (take) state_next = ST_STEP1;
      end
      ST_STEP1: begin
        cmd.step1  = 1'b1;
        state_next = ST_STEP2;
      end
      ST_STEP2: begin
        cmd.step2  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = take ? ST_STEP1 : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/sarb_dp.sv =====
`timescale 1ns / 1ps
// datapath for the stereo audio ring buffer: sample memory, pointers, result register
// depends on sarb_pkg

module sarb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  sarb_pkg::cmd_t                cmd,
  output sarb_pkg::status_t             status,
  input  logic                          in_op,
  input  sarb_pkg::sample_t             in_first,
  input  sarb_pkg::sample_t             in_second,
  input  logic [sarb_pkg::CHAN_W-1:0]   in_channels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sarb_pkg::sample_t             out_sample,
  output logic                          out_underrun,
  output logic                          out_accepted,
  output logic [sarb_pkg::DROP_W-1:0]   out_dropped
);

  sarb_pkg::sample_t mem [sarb_pkg::RING_DEPTH];
  sarb_pkg::sample_t rdata;

  logic              output_open;
  sarb_pkg::ptr_t    wr_ptr;
  sarb_pkg::ptr_t    rd_ptr;
  sarb_pkg::ptr_t    wr_ptr_next;

  logic              item_op;
  sarb_pkg::sample_t item_first;
  sarb_pkg::sample_t item_second;
  logic              item_mono;
  logic              item_underrun;
  logic              item_accepted;
  logic [sarb_pkg::DROP_W-1:0] item_dropped;

  logic              do_push;
  logic              do_pop;
  sarb_pkg::sample_t push_sample;

  assign status.out_free = !out_valid || out_ready;

  assign do_push     = (item_op == sarb_pkg::OP_PUSH) && output_open && (cmd.step1 || cmd.step2);
  assign do_pop      = (item_op == sarb_pkg::OP_POP) && cmd.step1 && (wr_ptr != rd_ptr);
  assign push_sample = (cmd.step2 && !item_mono) ? item_second : item_first;
  assign wr_ptr_next = sarb_pkg::ring_next(wr_ptr);

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_sample;
    if (do_pop) rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op     <= in_op;
      item_first  <= in_first;
      item_second <= in_second;
      item_mono   <= (in_channels == sarb_pkg::CHAN_W'(1));
    end
  end

  // pointers and the open flag; opening empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      output_open <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
    end else if (cfg_we) begin
      output_open <= cfg_wdata;
      if (cfg_wdata) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
      end
    end else if (do_push) begin
      wr_ptr <= wr_ptr_next;
      // full ring: drop the oldest sample
      if (wr_ptr_next == rd_ptr) rd_ptr <= sarb_pkg::ring_next(rd_ptr);
    end else if (do_pop) begin
      rd_ptr <= sarb_pkg::ring_next(rd_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step1) begin
      item_underrun <= (item_op == sarb_pkg::OP_POP) && (wr_ptr == rd_ptr);
      item_accepted <= (item_op == sarb_pkg::OP_PUSH) && output_open;
      item_dropped  <= (do_push && (wr_ptr_next == rd_ptr)) ? sarb_pkg::DROP_W'(1) : '0;
    end else if (do_push && (wr_ptr_next == rd_ptr)) begin
      item_dropped <= item_dropped + sarb_pkg::DROP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_sample   <= ((item_op == sarb_pkg::OP_POP) && !item_underrun) ? rdata : '0;
      out_underrun <= item_underrun;
      out_accepted <= item_accepted;
      out_dropped  <= item_dropped;
    end
  end

endmodule

// ===== rtl/stereo_audio_ring_buffer_unit.sv =====
`timescale 1ns / 1ps
// top level of the stereo audio ring buffer
// depends on sarb_pkg, sarb_ctrl, sarb_dp

// Interleaved stereo sample ring of sarb_pkg::RING_DEPTH 16-bit entries that
// drops the oldest sample when full (holds at most depth-1 samples). A push
// beat (tuser 0) stores the first two channel samples of a frame, or two
// copies of the first one for a mono frame, and is refused while the output
// is closed. A pop beat (tuser 1) returns one sample, or silence with tuser
// set on underrun. Every input beat gives exactly one output beat. An item
// passes the step1 and step2 states and is loaded in done, since both samples
// of a push go through the single write port of the sample memory one per
// cycle and a pop follows the same step sequence, with its registered read in
// the first step; the next beat is taken in the cycle the result is loaded,
// so no new item enters while one is in progress, and the load waits while
// the output stalls. Writing 1 to cfg_wdata opens the output and empties the
// ring; writing 0 closes it and keeps the contents. Reset leaves the output
// closed and the ring empty; the memory needs no clearing pass.

module stereo_audio_ring_buffer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_first[15:0], sample_second[31:16], channel_count[35:32], zero[39:36]
  input  logic [sarb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  // block_end, carried for framing only
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // sample_out[15:0], accepted[16], overwritten[18:17], zero[23:19]
  output logic [sarb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // underrun
  output logic                           m_axis_tuser
);

  sarb_pkg::cmd_t    cmd;
  sarb_pkg::status_t status;
  sarb_pkg::sample_t out_sample;
  logic              out_accepted;
  logic [sarb_pkg::DROP_W-1:0] out_dropped;
  logic              frame_end_unused;

  // block_end has no effect on the ring
  assign frame_end_unused = s_axis_tlast;

  sarb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sarb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .in_op        (s_axis_tuser),
    .in_first     (s_axis_tdata[15:0]),
    .in_second    (s_axis_tdata[31:16]),
    .in_channels  (s_axis_tdata[35:32]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_sample   (out_sample),
    .out_underrun (m_axis_tuser),
    .out_accepted (out_accepted),
    .out_dropped  (out_dropped)
  );

  assign m_axis_tdata = {5'b0, out_dropped, out_accepted, out_sample};

endmodule

// ===== dv/tb_stereo_audio_ring_buffer_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the stereo audio ring buffer top level
// depends on sarb_pkg and stereo_audio_ring_buffer_unit

module tb_stereo_audio_ring_buffer_unit;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    sarb_pkg::sample_t sample;
    bit                underrun;
    bit                accepted;
    logic [1:0]        dropped;
  } ring_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic                            cfg_wdata = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sarb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            s_axis_tlast = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b1;
  logic [sarb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  stereo_audio_ring_buffer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  sarb_pkg::sample_t ring_mem [sarb_pkg::RING_DEPTH];
  sarb_pkg::ptr_t    wr_ptr = '0;
  sarb_pkg::ptr_t    rd_ptr = '0;
  bit                out_open = 1'b0;

  ring_result_t expected_beats [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int frames_sent = 0;
  int beats_checked = 0;
  int underruns_seen = 0;
  int drops_seen = 0;
  int refused_seen = 0;
  int cycle_count = 0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  function automatic sarb_pkg::ptr_t bump(sarb_pkg::ptr_t p);
    return (p == sarb_pkg::ptr_t'(sarb_pkg::RING_DEPTH - 1)) ? '0 : p + sarb_pkg::ptr_t'(1);
  endfunction

  // store one sample, report whether the oldest one fell out
  function bit store_sample(sarb_pkg::sample_t s);
    ring_mem[wr_ptr] = s;
    wr_ptr = bump(wr_ptr);
    if (wr_ptr == rd_ptr) begin
      rd_ptr = bump(rd_ptr);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function ring_result_t predict_ring_beat(logic op, sarb_pkg::sample_t first,
                                           sarb_pkg::sample_t second,
                                           logic [sarb_pkg::CHAN_W-1:0] chans);
    ring_result_t r;
    r = '{sample: '0, underrun: 1'b0, accepted: 1'b0, dropped: 2'd0};
    if (op == sarb_pkg::OP_PUSH) begin
      if (out_open) begin
        r.accepted = 1'b1;
        r.dropped = 2'(store_sample(first));
        r.dropped = r.dropped + 2'(store_sample((chans == 4'd1) ? first : second));
      end
    end else if (wr_ptr == rd_ptr) begin
      r.underrun = 1'b1;
    end else begin
      r.sample = ring_mem[rd_ptr];
      rd_ptr = bump(rd_ptr);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_r = expected_beats.pop_front();
        beats_checked++;
        if (m_axis_tuser) underruns_seen++;
        drops_seen += m_axis_tdata[18:17];
        if (m_axis_tdata[15:0] !== exp_r.sample) begin
          $error("sample_out: expected %h, got %h", exp_r.sample, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tuser !== exp_r.underrun) begin
          $error("underrun: expected %b, got %b", exp_r.underrun, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[16] !== exp_r.accepted) begin
          $error("accepted: expected %b, got %b", exp_r.accepted, m_axis_tdata[16]);
          errors++;
        end
        if (m_axis_tdata[18:17] !== exp_r.dropped) begin
          $error("overwritten: expected %0d, got %0d", exp_r.dropped, m_axis_tdata[18:17]);
          errors++;
        end
        if (m_axis_tdata[23:19] !== 5'd0) begin
          $error("pad bits: expected 0, got %h", m_axis_tdata[23:19]);
          errors++;
        end
      end
    end
  end

  // called and returns on a falling edge
  task automatic send_item(input logic op, input sarb_pkg::sample_t first,
                           input sarb_pkg::sample_t second,
                           input logic [sarb_pkg::CHAN_W-1:0] chans, input logic last);
    ring_result_t r;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tlast = last;
    s_axis_tdata = {4'd0, chans, second, first};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_ring_beat(op, first, second, chans);
    if (op == sarb_pkg::OP_PUSH && !r.accepted) refused_seen++;
    expected_beats.push_back(r);
    frames_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic pop_sample();
    send_item(sarb_pkg::OP_POP, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              sarb_pkg::CHAN_W'($urandom), 1'($urandom));
  endtask

  task automatic push_random_frame();
    logic [sarb_pkg::CHAN_W-1:0] chans;
    chans = ($urandom_range(99) < 30) ? sarb_pkg::CHAN_W'(1) :
                                        sarb_pkg::CHAN_W'($urandom_range(15));
    send_item(sarb_pkg::OP_PUSH, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              chans, 1'($urandom));
  endtask

  task automatic wait_drain();
    while (expected_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_output_open(input logic value);
    wait_drain();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    out_open = value;
    if (value) begin
      wr_ptr = '0;
      rd_ptr = '0;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_closed_after_reset();
    send_item(sarb_pkg::OP_PUSH, 16'h1234, 16'h5678, 4'd2, 1'b0);
    pop_sample();
  endtask

  task automatic test_push_pop_extremes();
    write_output_open(1'b1);
    send_item(sarb_pkg::OP_PUSH, 16'h8000, 16'h7fff, 4'd1, 1'b0);  // mono copies first
    send_item(sarb_pkg::OP_PUSH, 16'h7fff, 16'h8000, 4'd2, 1'b0);
    send_item(sarb_pkg::OP_PUSH, 16'hffff, 16'h0000, 4'd8, 1'b1);
    send_item(sarb_pkg::OP_PUSH, 16'h0000, 16'hffff, 4'd0, 1'b0);   // zero channels acts as stereo
    send_item(sarb_pkg::OP_PUSH, 16'h5a5a, 16'ha5a5, 4'd15, 1'b1);  // above eight acts as stereo
    repeat (10) pop_sample();
    pop_sample();  // ring now empty
  endtask

  task automatic test_close_keeps_contents();
    send_item(sarb_pkg::OP_PUSH, 16'h0f0f, 16'hf0f0, 4'd2, 1'b0);
    write_output_open(1'b0);
    send_item(sarb_pkg::OP_PUSH, 16'h1111, 16'h2222, 4'd2, 1'b1);  // refused
    pop_sample();
    pop_sample();
    pop_sample();
    send_item(sarb_pkg::OP_PUSH, 16'h3333, 16'h4444, 4'd1, 1'b0);
    write_output_open(1'b1);
    pop_sample();  // reopening emptied the ring
    send_item(sarb_pkg::OP_PUSH, 16'h6666, 16'h7777, 4'd3, 1'b0);
    write_output_open(1'b1);
    pop_sample();
  endtask

  // fill to one short of full, then overflow by one and by two samples, then drain
  task automatic test_ring_overflow();
    write_output_open(1'b1);
    repeat ((sarb_pkg::RING_DEPTH - 2) / 2) push_random_frame();
    send_item(sarb_pkg::OP_PUSH, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              4'd2, 1'b0);
    send_item(sarb_pkg::OP_PUSH, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              4'd1, 1'b1);
    send_item(sarb_pkg::OP_PUSH, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              4'd0, 1'b0);
    send_item(sarb_pkg::OP_PUSH, sarb_pkg::sample_t'($urandom), sarb_pkg::sample_t'($urandom),
              4'd9, 1'b1);
    repeat (sarb_pkg::RING_DEPTH) pop_sample();
    wait_drain();
  endtask

  task automatic test_random_traffic(input int sender_idle, input int recv_stall,
                                     input int n_items, input int pop_pct);
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) write_output_open(1'($urandom_range(1)));
      if ($urandom_range(99) < pop_pct) pop_sample();
      else push_random_frame();
    end
    // hold the sender until the block has answered everything
    wait_drain();
    if (!out_open) write_output_open(1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_closed_after_reset();
    test_push_pop_extremes();
    test_close_keeps_contents();
    test_ring_overflow();
    test_random_traffic(0, 0, 100, 40);
    test_random_traffic(82, 0, 100, 60);
    test_random_traffic(0, 82, 100, 35);
    test_random_traffic(10, 10, 100, 50);

    idle_pct = 0;
    stall_pct = 0;
    wait_drain();
    repeat (10) @(posedge clk);

    $display("covered %0d beats in, %0d checked out: %0d underruns, %0d refused pushes,",
             frames_sent, beats_checked, underruns_seen, refused_seen);
    $display("%0d samples dropped on overflow, output toggled open and closed",
             drops_seen);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d beats missing", errors, expected_beats.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sarb_pkg.sv
rtl/sarb_ctrl.sv
rtl/sarb_dp.sv
rtl/stereo_audio_ring_buffer_unit.sv
dv/tb_stereo_audio_ring_buffer_unit.sv
